@@ rtl/core/crank_24_tooth_cam_sync_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the crank decoder
// Shared concurrent assertion forms, clocked on the rising edge and switched
// off while reset is high.
// ----------------------------------------------------------------------------
`ifndef CRANK_24_TOOTH_CAM_SYNC_DECODER_MACROS_SVH
`define CRANK_24_TOOTH_CAM_SYNC_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTSD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crank decoder: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CTSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crank decoder: next-cycle check failed");

`endif

@@ rtl/core/ctsd_pkg.sv @@
// ----------------------------------------------------------------------------
// Crank decoder package
// Codes, constants, the tooth angle table and the word types shared by the
// crank decoder modules.
// ----------------------------------------------------------------------------
package ctsd_pkg;

   // Input word function codes.
   localparam logic [1:0] FUNC_TOOTH = 2'd0;
   localparam logic [1:0] FUNC_CAM   = 2'd1;
   localparam logic [1:0] FUNC_QUERY = 2'd2;

   // Configuration register indexes.
   localparam logic       CSR_ANGLE_OFFSET = 1'b0;
   localparam logic       CSR_CYCLE_MAX    = 1'b1;

   // Tooth counter codes and reset values.
   localparam logic [4:0] TOOTH_UNSYNCED  = 5'd25;
   localparam logic [4:0] TOOTH_LAST      = 5'd24;
   localparam logic [4:0] TOOTH_FIRST     = 5'd1;
   localparam logic [4:0] GAP_RESET       = 5'd15;
   localparam logic [9:0] CYCLE_MAX_RESET = 10'd720;

   // Travel estimate: elapsed bits kept for the multiplier, fraction bits of
   // the speed, and the travel ceiling. Any elapsed time of 2^25 us or more
   // at a non-zero speed is already past the ceiling.
   localparam int         MUL_BITS   = 25;
   localparam int         FRAC_BITS  = 16;
   localparam logic [8:0] TRAVEL_CAP = 9'd360;

   // Angle arithmetic constants, signed 12 bits.
   localparam logic signed [11:0] DEG_360 = 12'sd360;
   localparam logic signed [11:0] DEG_719 = 12'sd719;
   localparam logic signed [11:0] DEG_720 = 12'sd720;

   // Word held between the tracking stage and the angle stage.
   typedef struct packed {
      logic                  sync_ok;
      logic [4:0]            tooth_number;
      logic [4:0]            gap_angle;
      logic [31:0]           tooth_period;
      logic                  second_revolution;
      logic                  tooth_accepted;
      logic [15:0]           start_revs;
      logic                  count_overflow;
      logic                  is_query;
      logic signed [11:0]    base_angle;
      logic [MUL_BITS-1:0]   elapsed_lo;
      logic                  elapsed_big;
      logic [15:0]           speed;
      logic [9:0]            cycle_max;
   } stg_type;

   // Result word.
   typedef struct packed {
      logic        sync_ok;
      logic [4:0]  tooth_number;
      logic [4:0]  gap_angle;
      logic [31:0] tooth_period;
      logic        second_revolution;
      logic        tooth_accepted;
      logic [15:0] start_revs;
      logic [9:0]  crank_angle;
      logic        count_overflow;
   } rsp_type;

   // Angle of each tooth of the wheel, in degrees, indexed from zero.
   function automatic logic [8:0] tooth_deg(input logic [4:0] idx);
      logic [8:0] deg;
      unique case (idx)
         5'd0:    deg = 9'd12;
         5'd1:    deg = 9'd18;
         5'd2:    deg = 9'd33;
         5'd3:    deg = 9'd48;
         5'd4:    deg = 9'd63;
         5'd5:    deg = 9'd78;
         5'd6:    deg = 9'd102;
         5'd7:    deg = 9'd108;
         5'd8:    deg = 9'd123;
         5'd9:    deg = 9'd138;
         5'd10:   deg = 9'd162;
         5'd11:   deg = 9'd177;
         5'd12:   deg = 9'd183;
         5'd13:   deg = 9'd198;
         5'd14:   deg = 9'd222;
         5'd15:   deg = 9'd237;
         5'd16:   deg = 9'd252;
         5'd17:   deg = 9'd258;
         5'd18:   deg = 9'd282;
         5'd19:   deg = 9'd288;
         5'd20:   deg = 9'd312;
         5'd21:   deg = 9'd327;
         5'd22:   deg = 9'd342;
         5'd23:   deg = 9'd357;
         default: deg = 9'd0;
      endcase
      return deg;
   endfunction

   // Gap between the tooth that the count moves to and the one before it.
   function automatic logic [4:0] gap_after(input logic [4:0] cnt);
      logic [8:0] diff;
      diff = tooth_deg(cnt) - tooth_deg(cnt - 5'd1);
      return diff[4:0];
   endfunction

endpackage

@@ rtl/core/ctsd_if.sv @@
// ----------------------------------------------------------------------------
// Crank decoder channels
// Valid/ready channels for the request words and the result words.
// ----------------------------------------------------------------------------
interface ctsd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [31:0] event_time;
   logic [15:0] speed_deg_per_us;

   modport source (output valid, output func, output event_time,
                   output speed_deg_per_us, input ready);
   modport sink   (input valid, input func, input event_time,
                   input speed_deg_per_us, output ready);
endinterface

interface ctsd_rsp_if;
   logic        valid;
   logic        ready;
   logic        sync_ok;
   logic [4:0]  tooth_number;
   logic [4:0]  gap_angle;
   logic [31:0] tooth_period;
   logic        second_revolution;
   logic        tooth_accepted;
   logic [15:0] start_revs;
   logic [9:0]  crank_angle;
   logic        count_overflow;

   modport source (output valid, output sync_ok, output tooth_number,
                   output gap_angle, output tooth_period,
                   output second_revolution, output tooth_accepted,
                   output start_revs, output crank_angle,
                   output count_overflow, input ready);
   modport sink   (input valid, input sync_ok, input tooth_number,
                   input gap_angle, input tooth_period,
                   input second_revolution, input tooth_accepted,
                   input start_revs, input crank_angle,
                   input count_overflow, output ready);
endinterface

@@ rtl/core/ctsd_track.sv @@
// ----------------------------------------------------------------------------
// Crank decoder tooth tracker
// Holds the wheel position state and configuration, updates the state on
// each accepted word and registers the stage word for the angle stage.
// ----------------------------------------------------------------------------
`include "crank_24_tooth_cam_sync_decoder_macros.svh"

module ctsd_track #(
   parameter int TIME_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   ctsd_req_if.sink                req,
   input  logic                    csr_write,
   input  logic                    csr_index,
   input  logic [9:0]              csr_data,
   output logic                    stg_valid,
   input  logic                    stg_ready,
   output ctsd_pkg::stg_type       stg
);
   import ctsd_pkg::*;

   // Position state and configuration.
   logic [4:0]           tooth_count_ff,    tooth_count_in;
   logic [TIME_BITS-1:0] last_time_ff,      last_time_in;
   logic                 rev_flag_ff,       rev_flag_in;
   logic                 synced_ff,         synced_in;
   logic [15:0]          rev_counter_ff,    rev_counter_in;
   logic [4:0]           gap_ff,            gap_in;
   logic [9:0]           angle_offset_ff;
   logic [9:0]           cycle_max_ff;

   // Stage register.
   logic                 stg_valid_ff;
   stg_type              stg_ff,            stg_in;

   logic                 req_fire;
   logic [TIME_BITS-1:0] now;
   logic [TIME_BITS-1:0] elapsed;
   logic [63:0]          elapsed_wide;
   logic                 is_synced_count;
   logic [8:0]           tooth_angle;
   logic [31:0]          period;
   logic                 accepted;
   logic                 overflow;

   assign req.ready = !stg_valid_ff || stg_ready;
   assign req_fire  = req.valid && req.ready;

   assign now             = TIME_BITS'(req.event_time);
   assign elapsed         = now - last_time_ff;
   assign elapsed_wide    = 64'(elapsed);
   assign is_synced_count = (tooth_count_ff < TOOTH_UNSYNCED);
   assign tooth_angle     = (tooth_count_ff != 5'd0) ? tooth_deg(tooth_count_ff - 5'd1)
                                                     : 9'd0;

   // Next state and flags for the word being accepted.
   always_comb begin
      tooth_count_in = tooth_count_ff;
      last_time_in   = last_time_ff;
      rev_flag_in    = rev_flag_ff;
      synced_in      = synced_ff;
      rev_counter_in = rev_counter_ff;
      gap_in         = gap_ff;
      period         = 32'd0;
      accepted       = 1'b0;
      overflow       = 1'b0;
      unique case (req.func)
         FUNC_TOOTH: begin
            if (!is_synced_count) begin
               synced_in = 1'b0;
            end else begin
               period       = 32'(elapsed);
               accepted     = 1'b1;
               last_time_in = now;
               priority if (tooth_count_ff == 5'd0) begin
                  tooth_count_in = TOOTH_FIRST;
                  rev_flag_in    = !rev_flag_ff;
                  synced_in      = 1'b1;
                  rev_counter_in = rev_counter_ff + 16'd1;
                  gap_in         = GAP_RESET;
               end else if (tooth_count_ff >= TOOTH_LAST) begin
                  tooth_count_in = TOOTH_LAST;
                  overflow       = 1'b1;
               end else begin
                  tooth_count_in = tooth_count_ff + 5'd1;
                  gap_in         = gap_after(tooth_count_ff);
               end
            end
         end
         FUNC_CAM: begin
            tooth_count_in = 5'd0;
            rev_flag_in    = 1'b1;
         end
         default: begin
            // Queries and the unused code leave the state alone.
         end
      endcase
   end

   // Stage word: the state after the word, plus the query operands.
   always_comb begin
      stg_in.sync_ok           = synced_in;
      stg_in.tooth_number      = tooth_count_in;
      stg_in.gap_angle         = gap_in;
      stg_in.tooth_period      = period;
      stg_in.second_revolution = rev_flag_in;
      stg_in.tooth_accepted    = accepted;
      stg_in.start_revs        = rev_counter_in;
      stg_in.count_overflow    = overflow;
      stg_in.is_query          = (req.func == FUNC_QUERY) && is_synced_count;
      stg_in.base_angle        = $signed({{2{angle_offset_ff[9]}}, angle_offset_ff})
                               + $signed({3'b000, tooth_angle})
                               + (rev_flag_ff ? DEG_360 : 12'sd0);
      stg_in.elapsed_lo        = elapsed_wide[MUL_BITS-1:0];
      stg_in.elapsed_big       = (elapsed_wide[63:MUL_BITS] != '0);
      stg_in.speed             = req.speed_deg_per_us;
      stg_in.cycle_max         = cycle_max_ff;
   end

   // State, configuration and stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tooth_count_ff  <= TOOTH_UNSYNCED;
         last_time_ff    <= '0;
         rev_flag_ff     <= 1'b0;
         synced_ff       <= 1'b0;
         rev_counter_ff  <= 16'd0;
         gap_ff          <= GAP_RESET;
         angle_offset_ff <= 10'd0;
         cycle_max_ff    <= CYCLE_MAX_RESET;
         stg_valid_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_ANGLE_OFFSET) begin
               angle_offset_ff <= csr_data;
            end else begin
               cycle_max_ff <= csr_data;
            end
         end
         if (req_fire) begin
            tooth_count_ff <= tooth_count_in;
            last_time_ff   <= last_time_in;
            rev_flag_ff    <= rev_flag_in;
            synced_ff      <= synced_in;
            rev_counter_ff <= rev_counter_in;
            gap_ff         <= gap_in;
            stg_valid_ff   <= 1'b1;
         end else if (stg_ready) begin
            stg_valid_ff <= 1'b0;
         end
      end
   end

   // Stage payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         stg_ff <= stg_in;
      end
   end

   assign stg_valid = stg_valid_ff;
   assign stg       = stg_ff;

   // The tooth count never leaves its code range, and an unsynced count
   // cannot coexist with the sync flag.
   `CTSD_ASSERT_SAME(a_count_range, clock, reset, 1'b1, tooth_count_ff <= TOOTH_UNSYNCED)
   `CTSD_ASSERT_SAME(a_unsynced_flag, clock, reset, tooth_count_ff == TOOTH_UNSYNCED, !synced_ff)
   `CTSD_ASSERT_NEXT(a_cam_resets, clock, reset, req_fire && req.func == FUNC_CAM,
                     tooth_count_ff == 5'd0 && rev_flag_ff && stg_ff.tooth_number == 5'd0)

endmodule

@@ rtl/core/ctsd_angle.sv @@
// ----------------------------------------------------------------------------
// Crank decoder angle stage
// Estimates the travel since the last tooth, adds it to the tooth angle and
// wraps the sum into the engine cycle, forming the result word.
// ----------------------------------------------------------------------------
module ctsd_angle (
   input  ctsd_pkg::stg_type  stg,
   output ctsd_pkg::rsp_type  rsp
);
   import ctsd_pkg::*;

   logic [MUL_BITS+FRAC_BITS-1:0] product;
   logic [MUL_BITS-1:0]           quotient;
   logic [8:0]                    travel;
   logic signed [11:0]            cmax;
   logic signed [11:0]            sum0;
   logic signed [11:0]            sum1;
   logic signed [11:0]            sum2;
   logic signed [11:0]            sum3;
   logic signed [11:0]            sum4;

   // Travel in degrees: elapsed time times speed, scaled down and capped.
   assign product  = (MUL_BITS+FRAC_BITS)'(stg.elapsed_lo)
                   * (MUL_BITS+FRAC_BITS)'(stg.speed);
   assign quotient = product[MUL_BITS+FRAC_BITS-1:FRAC_BITS];

   always_comb begin
      priority if (stg.speed == 16'd0) begin
         travel = 9'd0;
      end else if (stg.elapsed_big || (quotient > MUL_BITS'(TRAVEL_CAP))) begin
         travel = TRAVEL_CAP;
      end else begin
         travel = quotient[8:0];
      end
   end

   // Wrap the sum into the cycle.
   assign cmax = $signed({2'b00, stg.cycle_max});
   assign sum0 = stg.base_angle + $signed({3'b000, travel});
   assign sum1 = (sum0 >= DEG_720) ? (sum0 - DEG_720) : sum0;
   assign sum2 = (sum1 > cmax) ? (sum1 - cmax) : sum1;
   assign sum3 = (sum2 < 12'sd0) ? (sum2 + DEG_360) : sum2;

   // Anything still outside the 0 to 719 degree range lies within 720 degrees of it.
   always_comb begin
      priority if (sum3 < 12'sd0) begin
         sum4 = sum3 + DEG_720;
      end else if (sum3 > DEG_719) begin
         sum4 = sum3 - DEG_720;
      end else begin
         sum4 = sum3;
      end
   end

   // Result word.
   always_comb begin
      rsp.sync_ok           = stg.sync_ok;
      rsp.tooth_number      = stg.tooth_number;
      rsp.gap_angle         = stg.gap_angle;
      rsp.tooth_period      = stg.tooth_period;
      rsp.second_revolution = stg.second_revolution;
      rsp.tooth_accepted    = stg.tooth_accepted;
      rsp.start_revs        = stg.start_revs;
      rsp.crank_angle       = stg.is_query ? sum4[9:0] : 10'd0;
      rsp.count_overflow    = stg.count_overflow;
   end

endmodule

@@ rtl/core/ctsd_outbuf.sv @@
// ----------------------------------------------------------------------------
// Crank decoder output buffer
// Two-word output register with a skid stage, so that a word can be taken
// in while the receiver stalls.
// ----------------------------------------------------------------------------
`include "crank_24_tooth_cam_sync_decoder_macros.svh"

module ctsd_outbuf (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  ctsd_pkg::rsp_type  in_data,
   ctsd_rsp_if.source         rsp
);
   import ctsd_pkg::*;

   logic    out_valid_ff;
   logic    skid_valid_ff;
   rsp_type out_ff;
   rsp_type skid_ff;
   logic    in_fire;
   logic    out_take;

   assign in_ready = !skid_valid_ff;
   assign in_fire  = in_valid && in_ready;
   assign out_take = out_valid_ff && rsp.ready;

   // Occupancy of the two stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         priority if (skid_valid_ff) begin
            if (out_take) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (in_fire) begin
            if (out_valid_ff && !out_take) begin
               skid_valid_ff <= 1'b1;
            end else begin
               out_valid_ff <= 1'b1;
            end
         end else if (out_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload moves without reset.
   always_ff @(posedge clock) begin
      priority if (skid_valid_ff) begin
         if (out_take) begin
            out_ff <= skid_ff;
         end
      end else if (in_fire) begin
         if (out_valid_ff && !out_take) begin
            skid_ff <= in_data;
         end else begin
            out_ff <= in_data;
         end
      end
   end

   assign rsp.valid             = out_valid_ff;
   assign rsp.sync_ok           = out_ff.sync_ok;
   assign rsp.tooth_number      = out_ff.tooth_number;
   assign rsp.gap_angle         = out_ff.gap_angle;
   assign rsp.tooth_period      = out_ff.tooth_period;
   assign rsp.second_revolution = out_ff.second_revolution;
   assign rsp.tooth_accepted    = out_ff.tooth_accepted;
   assign rsp.start_revs        = out_ff.start_revs;
   assign rsp.crank_angle       = out_ff.crank_angle;
   assign rsp.count_overflow    = out_ff.count_overflow;

   // The skid stage only fills behind a held output word, and drains into it.
   `CTSD_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `CTSD_ASSERT_NEXT(a_skid_fills, clock, reset, in_fire && out_valid_ff && !rsp.ready,
                     skid_valid_ff && out_valid_ff)
   `CTSD_ASSERT_NEXT(a_skid_drains, clock, reset, skid_valid_ff && rsp.ready,
                     out_valid_ff && !skid_valid_ff)

endmodule

@@ rtl/core/crank_24_tooth_cam_sync_decoder.sv @@
// ----------------------------------------------------------------------------
// 24-tooth crank decoder with cam synchronisation
// Tracks an unevenly toothed crank wheel from tooth and cam words and
// answers crank angle queries, one result word for every request word.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries request words: a crank tooth, a cam pulse or an angle
//   query, each with a microsecond time stamp and the current speed.
//   rsp_ch returns one result word per request, in order, showing the
//   position state after that request and, for queries, the crank angle.
//   csr_write/csr_index/csr_data write the angle offset (index 0) and the
//   cycle length (index 1); write them only while no words are in flight.
// Pipeline and throughput:
//   A result word passes the tracking stage register, then the output
//   register. One request word is accepted every cycle unless a stall
//   holds the stage register; the tracking state is updated in the
//   accepting cycle, so consecutive words see each other's effect.
// Reset:
//   Synchronous reset drops synchronisation (tooth count unsynced), clears
//   the revolution counter, restores the register defaults and empties the
//   pipeline.
// Stall:
//   With rsp_ch stalled, up to three words are held (stage register, output
//   register and skid stage) before req_ch.ready falls.
// ----------------------------------------------------------------------------
module crank_24_tooth_cam_sync_decoder #(
   parameter int TIME_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   ctsd_req_if.sink     req_ch,
   ctsd_rsp_if.source   rsp_ch,
   input  logic         csr_write,
   input  logic         csr_index,
   input  logic [9:0]   csr_data
);
   import ctsd_pkg::*;

   logic    stg_valid;
   logic    stg_ready;
   stg_type stg;
   rsp_type rsp_word;

   // Position tracking and stage register.
   ctsd_track #(
      .TIME_BITS (TIME_BITS)
   ) u_track (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .stg_valid (stg_valid),
      .stg_ready (stg_ready),
      .stg       (stg)
   );

   // Angle estimate and wrap.
   ctsd_angle u_angle (
      .stg (stg),
      .rsp (rsp_word)
   );

   // Output register and skid stage.
   ctsd_outbuf u_outbuf (
      .clock    (clock),
      .reset    (reset),
      .in_valid (stg_valid),
      .in_ready (stg_ready),
      .in_data  (rsp_word),
      .rsp      (rsp_ch)
   );

endmodule
